// ===== rtl/u8d_pkg.sv =====
// types and constants shared by the utf-8 stream decoder modules
package u8d_pkg;

  // one raw byte of text in
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // one decoded result out
  typedef struct packed {
    logic [20:0] code_point;
    logic        substituted;
    logic        run_last;
  } out_item_t;

  // work handed from front to back: replacements first, then an optional value
  typedef struct packed {
    logic [2:0]  repl_count;
    logic        has_value;
    logic [20:0] value;
  } job_t;

  localparam logic [20:0] REPL_CP    = 21'h00FFFD;
  localparam logic [7:0]  ASCII_LIM  = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE = 8'hF0;
  localparam logic [7:0]  CONT_MASK  = 8'hC0;
  localparam logic [7:0]  CONT_CODE  = 8'h80;
  localparam logic [7:0]  BITS2_MASK = 8'h1F;
  localparam logic [7:0]  BITS3_MASK = 8'h0F;
  localparam logic [7:0]  BITS4_MASK = 8'h07;
  localparam logic [7:0]  CONT_BITS  = 8'h3F;

  localparam logic [2:0]  LEN2 = 3'd2;
  localparam logic [2:0]  LEN3 = 3'd3;
  localparam logic [2:0]  LEN4 = 3'd4;

endpackage

// ===== rtl/u8d_front.sv =====
// front end: takes bytes, tracks the open sequence and builds result jobs
module u8d_front import u8d_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t text,
  input  logic     accept,
  output job_t     job,
  output logic     job_valid
);

  logic        seq_active, seq_active_next;
  logic [2:0]  seq_length, seq_length_next;
  logic [1:0]  seq_count, seq_count_next;
  logic [20:0] seq_value, seq_value_next;

  logic [7:0]  b;
  logic        eot;
  logic        cont;
  logic [1:0]  count_inc;
  logic        fresh;
  logic [2:0]  repl;
  logic        has_value;
  logic [20:0] value;

  assign b         = text.text_byte;
  assign eot       = text.end_of_text;
  assign cont      = (b & CONT_MASK) == CONT_CODE;
  assign count_inc = seq_count + 2'd1;

  // classify the byte against the open sequence
  always_comb begin
    seq_active_next = seq_active;
    seq_length_next = seq_length;
    seq_count_next  = seq_count;
    seq_value_next  = seq_value;
    fresh           = 1'b0;
    repl            = 3'd0;
    has_value       = 1'b0;
    value           = '0;

    if (!seq_active) begin
      fresh = 1'b1;
    end else if (cont) begin
      seq_value_next = {seq_value[14:0], 6'(b & CONT_BITS)};
      seq_count_next = count_inc;
      if (({1'b0, count_inc} + 3'd1) >= seq_length) begin
        has_value       = 1'b1;
        value           = seq_value_next;
        seq_active_next = 1'b0;
        seq_length_next = 3'd0;
        seq_count_next  = 2'd0;
        seq_value_next  = '0;
      end else if (eot) begin
        repl            = 3'd1 + {1'b0, count_inc};
        seq_active_next = 1'b0;
        seq_length_next = 3'd0;
        seq_count_next  = 2'd0;
        seq_value_next  = '0;
      end
    end else begin
      // broken sequence: lead and held continuations replaced, byte decoded afresh
      repl            = 3'd1 + {1'b0, seq_count};
      seq_active_next = 1'b0;
      seq_length_next = 3'd0;
      seq_count_next  = 2'd0;
      seq_value_next  = '0;
      fresh           = 1'b1;
    end

    // decode a byte with no sequence open
    if (fresh) begin
      if (b < ASCII_LIM) begin
        has_value = 1'b1;
        value     = {13'd0, b};
      end else if ((b & LEAD2_MASK) == LEAD2_CODE ||
                   (b & LEAD3_MASK) == LEAD3_CODE ||
                   (b & LEAD4_MASK) == LEAD4_CODE) begin
        if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          seq_length_next = LEN2;
          seq_value_next  = {13'd0, b & BITS2_MASK};
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          seq_length_next = LEN3;
          seq_value_next  = {13'd0, b & BITS3_MASK};
        end else begin
          seq_length_next = LEN4;
          seq_value_next  = {13'd0, b & BITS4_MASK};
        end
        seq_active_next = 1'b1;
        seq_count_next  = 2'd0;
        if (eot) begin
          repl            = repl + 3'd1;
          seq_active_next = 1'b0;
          seq_length_next = 3'd0;
          seq_value_next  = '0;
        end
      end else begin
        repl = repl + 3'd1;
      end
    end
  end

  assign job.repl_count = repl;
  assign job.has_value  = has_value;
  assign job.value      = value;
  assign job_valid      = accept && ((repl != 3'd0) || has_value);

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_length <= 3'd0;
      seq_count  <= 2'd0;
      seq_value  <= '0;
    end else if (accept) begin
      seq_active <= seq_active_next;
      seq_length <= seq_length_next;
      seq_count  <= seq_count_next;
      seq_value  <= seq_value_next;
    end
  end

`ifndef SYNTHESIS
  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    seq_active |-> (seq_length == LEN2 || seq_length == LEN3 || seq_length == LEN4))
    else $error("open sequence with bad length");
  a_count_short: assert property (@(posedge clk) disable iff (rst)
    seq_active |-> (({1'b0, seq_count} + 3'd1) < seq_length))
    else $error("open sequence already complete");
`endif

endmodule

// ===== rtl/u8d_fifo.sv =====
// short job queue between front and back
module u8d_fifo import u8d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic head_valid,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == FULL_CNT;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job queue underflow");
`endif

endmodule

// ===== rtl/u8d_back.sv =====
// back end: expands each job into output register results, one per unstalled cycle
module u8d_back import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      cp_valid,
  input  logic      cp_stall,
  output out_item_t cp
);

  logic [2:0] pos;
  logic [2:0] total;
  logic       load;
  logic       last;
  out_item_t  res;

  assign total = head.repl_count + {2'd0, head.has_value};
  assign load  = head_valid && (!cp_valid || !cp_stall);
  assign last  = (pos + 3'd1) == total;
  assign pop   = load && last;

  // pick the result at the current position of the job
  always_comb begin
    if (pos < head.repl_count) begin
      res.code_point  = REPL_CP;
      res.substituted = 1'b1;
    end else begin
      res.code_point  = head.value;
      res.substituted = 1'b0;
    end
    res.run_last = last;
  end

  // position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else if (load) begin
      pos <= last ? 3'd0 : pos + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
    end else if (!cp_valid || !cp_stall) begin
      cp_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp <= res;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (pos < total))
    else $error("result position past end of job");
`endif

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// top level of the utf-8 stream decoder
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   text    | text_valid/stall    | text_byte, end_of_text
//   cp      | cp_valid/cp_stall   | code_point, substituted, run_last
//
// one byte is taken per cycle while the job queue has room; each byte yields 0 to 4
// results, and the back end sends one result per cycle while cp_stall is low, so a byte
// with n results holds the back end and the queue of QUEUE_DEPTH jobs absorbs that.
// a byte's job is registered in the job queue, its results in the output register.
// synchronous reset clears the sequence state, the queue and the output valid flag.
// text_stall is high only while the job queue is full.
module utf8_stream_decoder import u8d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  in_item_t  text,
  output logic      cp_valid,
  input  logic      cp_stall,
  output out_item_t cp
);

  logic accept;
  job_t job;
  logic job_valid;
  job_t head;
  logic head_valid;
  logic pop;
  logic full;

  assign text_stall = full;
  assign accept     = text_valid && !full;

  u8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .accept    (accept),
    .job       (job),
    .job_valid (job_valid)
  );

  u8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp         (cp)
  );

endmodule

// ===== verif/utf8_decode_checker.sv =====
// checker for the utf-8 stream decoder: predicts code points from accepted bytes and compares
`timescale 1ns / 100ps

module utf8_decode_checker import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  input  logic      text_stall,
  input  in_item_t  text,
  input  logic      cp_valid,
  input  logic      cp_stall,
  input  out_item_t cp,
  output int        fail_count,
  output int        pending
);

  // decoder state as the predictor sees it
  logic        in_seq;
  logic [2:0]  seq_len;
  logic [1:0]  held;
  logic [20:0] acc;

  out_item_t byte_results[$];
  out_item_t expected_cps[$];
  int        errors;

  assign fail_count = errors;

  task automatic add_result(input logic [20:0] value, input logic sub);
    out_item_t r;
    r.code_point = value;
    r.substituted = sub;
    r.run_last = 1'b0;
    byte_results.push_back(r);
  endtask

  task automatic close_sequence();
    in_seq = 1'b0;
    seq_len = '0;
    held = '0;
    acc = '0;
  endtask

  // replacement for the lead, then one per held continuation
  task automatic drop_sequence();
    int k;
    add_result(REPL_CP, 1'b1);
    for (k = 0; k < held; k++) add_result(REPL_CP, 1'b1);
    close_sequence();
  endtask

  // a byte seen with no sequence open
  task automatic start_byte(input logic [7:0] b, input logic eot);
    logic lead;
    lead = 1'b1;
    if (b < ASCII_LIM) begin
      add_result({13'd0, b}, 1'b0);
      lead = 1'b0;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      seq_len = LEN2;
      acc = {13'd0, b & BITS2_MASK};
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      seq_len = LEN3;
      acc = {13'd0, b & BITS3_MASK};
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      seq_len = LEN4;
      acc = {13'd0, b & BITS4_MASK};
    end else begin
      add_result(REPL_CP, 1'b1);
      lead = 1'b0;
    end
    if (lead) begin
      in_seq = 1'b1;
      held = '0;
      // a lead on the final byte is cut at once
      if (eot) drop_sequence();
    end
  endtask

  // expected results of one accepted byte, appended to the expected queue
  task automatic decode_byte(input in_item_t item);
    int k;
    byte_results.delete();
    if (!in_seq) begin
      start_byte(item.text_byte, item.end_of_text);
    end else if ((item.text_byte & CONT_MASK) == CONT_CODE) begin
      acc = {acc[14:0], item.text_byte[5:0]};
      held = held + 2'd1;
      if ({1'b0, held} + 3'd1 >= seq_len) begin
        add_result(acc, 1'b0);
        close_sequence();
      end else if (item.end_of_text) begin
        drop_sequence();
      end
    end else begin
      // broken sequence: flush, then decode the breaking byte afresh
      drop_sequence();
      start_byte(item.text_byte, item.end_of_text);
    end
    for (k = 0; k < byte_results.size(); k++) begin
      out_item_t r;
      r = byte_results[k];
      r.run_last = (k == byte_results.size() - 1);
      expected_cps.push_back(r);
    end
  endtask

  // compare each result transfer, then predict from each byte transfer
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      close_sequence();
      expected_cps.delete();
    end else begin
      if (cp_valid && !cp_stall) begin
        if (expected_cps.size() == 0) begin
          $error("code_point 0x%0h arrived with nothing expected", cp.code_point);
          errors++;
        end else begin
          want = expected_cps.pop_front();
          if (cp.code_point !== want.code_point) begin
            $error("code_point expected 0x%0h actual 0x%0h", want.code_point, cp.code_point);
            errors++;
          end
          if (cp.substituted !== want.substituted) begin
            $error("substituted expected %0b actual %0b", want.substituted, cp.substituted);
            errors++;
          end
          if (cp.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, cp.run_last);
            errors++;
          end
        end
      end
      if (text_valid && !text_stall) decode_byte(text);
    end
    pending <= expected_cps.size();
  end

endmodule

// ===== verif/testbench.sv =====
// testbench top for the utf-8 stream decoder: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module testbench import u8d_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 96;

  logic      clk;
  logic      rst;
  logic      text_valid;
  logic      text_stall;
  in_item_t  text;
  logic      cp_valid;
  logic      cp_stall;
  out_item_t cp;
  int        fail_count;
  int        pending;
  bit        calm;
  int        quiet_cycles;

  utf8_stream_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp         (cp)
  );

  utf8_decode_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .cp         (cp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // random stall on the result side, none during the calm stretch
  initial begin
    cp_stall = 1'b0;
    forever begin
      @(negedge clk);
      cp_stall <= !calm && ($urandom_range(99) < 6);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (cp_valid && !cp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one byte transfer, with an occasional gap before it; starts and ends at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic eot);
    while (!calm && ($urandom_range(99) < 6)) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text <= '{text_byte: b, end_of_text: eot};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // random text: mostly well-formed characters, some cut short, some noise
  task automatic random_text();
    logic [7:0] chunk[$];
    int sent;
    int kind;
    int len;
    int k;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      calm = (sent >= 40) && (sent < 80);
      chunk.delete();
      kind = $urandom_range(99);
      if (kind < 20) begin
        chunk.push_back(8'($urandom_range(127)));
      end else if (kind < 75) begin
        len = $urandom_range(4, 2);
        case (len)
          2: chunk.push_back(LEAD2_CODE | 8'($urandom_range(31)));
          3: chunk.push_back(LEAD3_CODE | 8'($urandom_range(15)));
          default: chunk.push_back(LEAD4_CODE | 8'($urandom_range(7)));
        endcase
        for (k = 1; k < len; k++) chunk.push_back(CONT_CODE | 8'($urandom_range(63)));
        // cut short so that the next character breaks it
        if (kind >= 65) chunk = chunk[0:$urandom_range(len - 2)];
      end else begin
        chunk.push_back(8'($urandom_range(255)));
      end
      foreach (chunk[i]) put_byte(chunk[i], $urandom_range(99) < 5);
      sent += chunk.size();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    text_valid = 1'b0;
    text = '0;
    calm = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ascii extremes
    put_byte(8'h00, 1'b0);
    put_byte(8'h7F, 1'b0);
    // two, three and four byte characters
    put_byte(8'hC2, 1'b0);
    put_byte(8'hA9, 1'b0);
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b0);
    put_byte(8'hAC, 1'b0);
    put_byte(8'hF0, 1'b0);
    put_byte(8'h9F, 1'b0);
    put_byte(8'h98, 1'b0);
    put_byte(8'h80, 1'b0);
    // largest value a four byte form can carry
    put_byte(8'hF7, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b0);
    // orphan continuation and invalid lead
    put_byte(8'h80, 1'b0);
    put_byte(8'hFF, 1'b0);
    // sequence broken by ascii after one continuation
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b0);
    put_byte(8'h41, 1'b0);
    // cut at end of text with a continuation held
    put_byte(8'hF0, 1'b0);
    put_byte(8'h9F, 1'b1);
    // lead on the final byte
    put_byte(8'hC3, 1'b1);
    // sequence broken by an invalid lead
    put_byte(8'hDF, 1'b0);
    put_byte(8'hF8, 1'b0);

    random_text();
    text_valid <= 1'b0;

    // drain what is still expected
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_fifo.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder.sv
verif/utf8_decode_checker.sv
verif/testbench.sv
